FILE: hw/rtl/busy_period_analyzer_core_macros.svh
// ----------------------------------------------------------------------------
// Busy period analyzer assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef BUSY_PERIOD_ANALYZER_CORE_MACROS_SVH
`define BUSY_PERIOD_ANALYZER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Busy period analyzer package
// Widths, constants and the broadcast control word of the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

    localparam int LIMIT_W           = 20;
    localparam int WORD_W            = 16;
    localparam int IDX_W             = 4;
    localparam int SUM_W             = LIMIT_W + 1;
    localparam int DEFAULT_MAX_TASKS = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};
    // one past the largest limit: every sum at or above it overflows
    localparam logic [SUM_W-1:0]   SUM_SAT     = {1'b1, {LIMIT_W{1'b0}}};

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_ANALYZE = 1'b1;

    typedef struct packed {
        logic             load;   // load dividend, clear remainder
        logic             step;   // one restoring division step
        logic             mul;    // form demand term, clear chain
        logic             shift;  // move sums one cell down the chain
        logic [IDX_W-1:0] task_sel;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bpa_cell.sv
// ----------------------------------------------------------------------------
// Busy period analyzer cell
// Holds one task entry, divides the window by its period bit-serially and
// adds its demand to the running sum passed down the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_cell
    import bpa_pkg::*;
#(
    parameter int CELL_ID = 0
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cell_ctl_t          ctl,
    input  wire logic               wr_en,
    input  wire logic [WORD_W-1:0]  wr_exec,
    input  wire logic [WORD_W-1:0]  wr_period,
    input  wire logic [LIMIT_W-1:0] dividend,
    input  wire logic [SUM_W-1:0]   sum_in,
    input  wire logic [SUM_W-1:0]   jobs_in,
    output logic      [SUM_W-1:0]   sum_out,
    output logic      [SUM_W-1:0]   jobs_out
);

    logic [WORD_W-1:0]        exec_reg;
    logic [WORD_W-1:0]        period_reg;
    logic [LIMIT_W-1:0]       quo_reg;
    logic [WORD_W-1:0]        rem_reg;
    logic [SUM_W-1:0]         term_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         jobs_reg;

    logic [WORD_W-1:0]        p_eff;
    logic [WORD_W:0]          trial;
    logic                     fits;
    logic [SUM_W-1:0]         n_jobs;
    logic [SUM_W+WORD_W-1:0]  prod;
    logic [SUM_W:0]           acc;
    logic                     active;
    logic                     is_task;

    assign p_eff   = (period_reg == '0) ? WORD_W'(1) : period_reg;
    assign trial   = {rem_reg, quo_reg[LIMIT_W-1]};
    assign fits    = trial >= {1'b0, p_eff};
    // ceil(t/p) = floor((t-1)/p) + 1
    assign n_jobs  = {1'b0, quo_reg} + SUM_W'(1);
    assign prod    = n_jobs * exec_reg;
    assign acc     = {1'b0, sum_in} + {1'b0, term_reg};
    assign active  = CELL_ID <= int'(ctl.task_sel);
    assign is_task = CELL_ID == int'(ctl.task_sel);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            exec_reg   <= wr_exec;
            period_reg <= wr_period;
        end
        if (ctl.load)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (ctl.step)
        begin
            if (fits)
            begin
                rem_reg <= WORD_W'(trial - {1'b0, p_eff});
                quo_reg <= {quo_reg[LIMIT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[WORD_W-1:0];
                quo_reg <= {quo_reg[LIMIT_W-2:0], 1'b0};
            end
        end
        if (ctl.mul)
        begin
            if (!active)
                term_reg <= '0;
            else if (prod > (SUM_W+WORD_W)'(SUM_SAT))
                term_reg <= SUM_SAT;
            else
                term_reg <= prod[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            jobs_reg <= '0;
        end
        else if (ctl.mul)
        begin
            sum_reg  <= '0;
            jobs_reg <= '0;
        end
        else if (ctl.shift)
        begin
            sum_reg  <= (acc > {1'b0, SUM_SAT}) ? SUM_SAT : acc[SUM_W-1:0];
            jobs_reg <= is_task ? n_jobs : jobs_in;
        end
    end

    assign sum_out  = sum_reg;
    assign jobs_out = jobs_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/busy_period_analyzer_core.sv
// ----------------------------------------------------------------------------
// Busy period analyzer core
// Level-i busy period search over a fixed-priority task table.
// ----------------------------------------------------------------------------
// Input beats on s_*: s_tuser = 0 writes exec/period of a task entry (no
// result); s_tuser = 1 analyzes task_index and yields one result beat on
// m_*: busy length, job count and an overflow flag (m_tuser).
// cfg_* writes time_limit; cfg_ready is always high.
// Each fixed-point iteration runs a load, 20 division steps, a multiply,
// MAX_TASKS chain shifts and a compare in turn; a query repeats it until
// the sum equals the window or overflows. The serial divider in every cell
// and the sum ripple down the chain make up most of each iteration.
// One query is in flight at a time; s_tready is high only while idle.
// The result sits in an output register, so the next beat can be taken
// while a finished result waits on m_tready; a second result waits in a
// finish state until the first is taken.
// Reset sets time_limit to its maximum and clears all control; the task
// table is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module busy_period_analyzer_core
    import bpa_pkg::*;
#(
    parameter int MAX_TASKS = DEFAULT_MAX_TASKS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [39:0]        s_tdata,   // task_index[3:0], exec_time[19:4],
                                               // period[35:20], zero pad
    input  wire logic               s_tuser,   // operation
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [39:0]        m_tdata,   // busy_length[19:0], job_count[39:20]
    output logic                    m_tuser,   // overflow
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [LIMIT_W-1:0] cfg_data
);

    localparam int DIV_STEPS = LIMIT_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int SCNT_W    = $clog2(MAX_TASKS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_CHK,
        ST_FIN
    } state_t;

    state_t              state_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [LIMIT_W-1:0]  t_reg;
    logic [IDX_W-1:0]    task_reg;
    logic [DCNT_W-1:0]   dcnt_reg;
    logic [SCNT_W-1:0]   scnt_reg;
    logic [LIMIT_W-1:0]  res_busy_reg;
    logic [LIMIT_W-1:0]  res_jobs_reg;
    logic                res_ovf_reg;
    logic                m_tvalid_reg;
    logic [LIMIT_W-1:0]  m_busy_reg;
    logic [LIMIT_W-1:0]  m_jobs_reg;
    logic                m_ovf_reg;

    logic [IDX_W-1:0]    in_idx;
    logic [WORD_W-1:0]   in_exec;
    logic [WORD_W-1:0]   in_period;
    logic [IDX_W-1:0]    idx_clamped;
    logic                in_fire;
    logic                out_free;
    cell_ctl_t           ctl;
    logic [SUM_W-1:0]    sum_chain  [MAX_TASKS+1];
    logic [SUM_W-1:0]    jobs_chain [MAX_TASKS+1];
    logic [SUM_W-1:0]    w_sum;

    assign in_idx    = s_tdata[3:0];
    assign in_exec   = s_tdata[19:4];
    assign in_period = s_tdata[35:20];
    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign w_sum     = sum_chain[MAX_TASKS];

    assign idx_clamped = (int'(in_idx) >= MAX_TASKS) ? IDX_W'(MAX_TASKS - 1) : in_idx;

    always_comb
    begin
        ctl          = '0;
        ctl.task_sel = task_reg;
        ctl.load     = state_reg == ST_LOAD;
        ctl.step     = state_reg == ST_DIV;
        ctl.mul      = state_reg == ST_MUL;
        ctl.shift    = state_reg == ST_SUM;
    end

    assign sum_chain[0]  = '0;
    assign jobs_chain[0] = '0;

    for (genvar k = 0; k < MAX_TASKS; k++)
    begin : g_cell
        bpa_cell #(
            .CELL_ID (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .wr_en     (in_fire && (s_tuser == OP_WRITE) && (int'(in_idx) == k)),
            .wr_exec   (in_exec),
            .wr_period (in_period),
            .dividend  (t_reg - LIMIT_W'(1)),
            .sum_in    (sum_chain[k]),
            .jobs_in   (jobs_chain[k]),
            .sum_out   (sum_chain[k+1]),
            .jobs_out  (jobs_chain[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            limit_reg    <= LIMIT_RESET;
            t_reg        <= '0;
            task_reg     <= '0;
            dcnt_reg     <= '0;
            scnt_reg     <= '0;
            res_busy_reg <= '0;
            res_jobs_reg <= '0;
            res_ovf_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_busy_reg   <= '0;
            m_jobs_reg   <= '0;
            m_ovf_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
            // in the finish state a taken beat is replaced below
            if (m_tvalid_reg && m_tready && (state_reg != ST_FIN))
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && (s_tuser == OP_ANALYZE))
                    begin
                        task_reg <= idx_clamped;
                        t_reg    <= LIMIT_W'(1);
                        if (limit_reg == '0)
                        begin
                            res_busy_reg <= '0;
                            res_jobs_reg <= '0;
                            res_ovf_reg  <= 1'b1;
                            state_reg    <= ST_FIN;
                        end
                        else
                            state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    dcnt_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    dcnt_reg <= dcnt_reg + DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                        state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    scnt_reg  <= '0;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    scnt_reg <= scnt_reg + SCNT_W'(1);
                    if (scnt_reg == SCNT_W'(MAX_TASKS - 1))
                        state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    if (w_sum == {1'b0, t_reg})
                    begin
                        res_busy_reg <= t_reg;
                        res_jobs_reg <= jobs_chain[MAX_TASKS][LIMIT_W-1:0];
                        res_ovf_reg  <= 1'b0;
                        state_reg    <= ST_FIN;
                    end
                    else if ((w_sum < {1'b0, t_reg}) || (w_sum > {1'b0, limit_reg}))
                    begin
                        res_busy_reg <= '0;
                        res_jobs_reg <= '0;
                        res_ovf_reg  <= 1'b1;
                        state_reg    <= ST_FIN;
                    end
                    else
                    begin
                        t_reg     <= w_sum[LIMIT_W-1:0];
                        state_reg <= ST_LOAD;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_busy_reg   <= res_busy_reg;
                        m_jobs_reg   <= res_jobs_reg;
                        m_ovf_reg    <= res_ovf_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_jobs_reg, m_busy_reg};
    assign m_tuser  = m_ovf_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/bpa_checker.sv
// ----------------------------------------------------------------------------
// Busy period analyzer port checker
// Watches the top-level ports for result consistency and beat handling.
// ----------------------------------------------------------------------------
`default_nettype none

`include "busy_period_analyzer_core_macros.svh"

module bpa_checker
    import bpa_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic [39:0]        s_tdata,
    input wire logic               s_tuser,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [39:0]        m_tdata,
    input wire logic               m_tuser,
    input wire logic               cfg_valid,
    input wire logic               cfg_ready,
    input wire logic [LIMIT_W-1:0] cfg_data
);

    logic [LIMIT_W-1:0] busy;
    logic [LIMIT_W-1:0] jobs;

    assign busy = m_tdata[19:0];
    assign jobs = m_tdata[39:20];

    `BPA_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result beat dropped")
    `BPA_ASSERT_NOW(a_ovf_zero, m_tvalid && m_tuser, m_tdata == 40'd0, "overflow with data")
    `BPA_ASSERT_NOW(a_fix_nonzero, m_tvalid && !m_tuser, busy != '0 && jobs != '0,
                    "zero busy period without overflow")
    `BPA_ASSERT_NOW(a_jobs_bound, m_tvalid && !m_tuser, jobs <= busy,
                    "job count exceeds busy period")

endmodule

bind busy_period_analyzer_core bpa_checker u_bpa_checker (.*);

`default_nettype wire

FILE: bench/busy_period_checker.sv
// ----------------------------------------------------------------------------
// Busy period checker
// Watches the input, config and result channels of the busy period analyzer.
// Keeps its own task table and time limit, predicts each analysis result and
// compares result beats in order against the predicted queue.
// ----------------------------------------------------------------------------
module busy_period_checker
    import bpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [39:0]        s_tdata,
    input  logic               s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [39:0]        m_tdata,
    input  logic               m_tuser,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic [LIMIT_W-1:0] busy_length;
        logic [LIMIT_W-1:0] job_count;
        logic               overflow;
    } busy_result_t;

    logic [WORD_W-1:0]  exec_tbl [16];
    logic [WORD_W-1:0]  per_tbl  [16];
    logic [LIMIT_W-1:0] limit_reg;
    busy_result_t       busy_q [$];

    function automatic longint unsigned eff_per(int unsigned k);
        return (per_tbl[k] == '0) ? 64'd1 : 64'(per_tbl[k]);
    endfunction

    function automatic longint unsigned ceil_q(longint unsigned a, longint unsigned b);
        return (a + b - 1) / b;
    endfunction

    function automatic busy_result_t predict_busy(int unsigned task_sel);
        longint unsigned t;
        longint unsigned w;
        busy_result_t    r;
        t = 1;
        r = '{busy_length: '0, job_count: '0, overflow: 1'b1};
        while (t <= 64'(limit_reg)) begin
            w = 0;
            for (int unsigned k = 0; k <= task_sel; k++)
                w += ceil_q(t, eff_per(k)) * 64'(exec_tbl[k]);
            if (w == t) begin
                r.busy_length = t[LIMIT_W-1:0];
                r.job_count   = LIMIT_W'(ceil_q(t, eff_per(task_sel)));
                r.overflow    = 1'b0;
                return r;
            end
            if (w < t)
                break;  // all execution times zero
            t = w;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("MISMATCH %s: got %0d, want %0d", what, got, want);
        errors++;
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        busy_result_t want;
        if (!rst_n)
        begin
            limit_reg = LIMIT_RESET;
            busy_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg = cfg_data;
            if (m_tvalid && m_tready)
            begin
                if (busy_q.size() == 0)
                    report_mismatch("unexpected result beat", m_tdata, 0);
                else
                begin
                    want = busy_q.pop_front();
                    if (m_tdata[19:0] !== want.busy_length)
                        report_mismatch("busy_length", m_tdata[19:0], want.busy_length);
                    if (m_tdata[39:20] !== want.job_count)
                        report_mismatch("job_count", m_tdata[39:20], want.job_count);
                    if (m_tuser !== want.overflow)
                        report_mismatch("overflow", m_tuser, want.overflow);
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_WRITE)
                begin
                    exec_tbl[s_tdata[3:0]] = s_tdata[19:4];
                    per_tbl[s_tdata[3:0]]  = s_tdata[35:20];
                end
                else
                    busy_q.push_back(predict_busy(s_tdata[3:0]));
            end
            pending = busy_q.size();
        end
    end

endmodule

FILE: bench/busy_period_analyzer_core_tb.sv
// ----------------------------------------------------------------------------
// Busy period analyzer testbench
// Drives table writes and analysis beats in random bursts over several time
// limit settings, stalls the result side at random and once for a long hold,
// and takes the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module busy_period_analyzer_core_tb;
    import bpa_pkg::*;

    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 20_000_000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata = '0;
    logic               s_tuser = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [39:0]        m_tdata;
    logic               m_tuser;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data = '0;
    int                 errors;
    int                 pending;

    int                 burst_left = 0;
    int                 beats_sent = 0;
    int                 hold_cnt = 0;
    bit                 hold_done = 0;
    int                 calm_cnt = 0;
    int                 cycles = 0;

    always #2 clk = ~clk;

    busy_period_analyzer_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    busy_period_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // result side: random stalls, calm stretches, one long hold mid-run
    always @(negedge clk)
    begin
        if (!hold_done && beats_sent == 200)
        begin
            hold_done <= 1'b1;
            hold_cnt  <= 400;
            m_tready  <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else if (calm_cnt > 0)
        begin
            calm_cnt <= calm_cnt - 1;
            m_tready <= 1'b1;
        end
        else
        begin
            if ($urandom_range(0, 49) == 0)
                calm_cnt <= $urandom_range(20, 200);
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("busy_period_analyzer_core_tb: done, errors");
            $finish;
        end
    end

    task automatic send_beat(logic op, logic [3:0] idx, logic [15:0] ex, logic [15:0] per);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, per, ex, idx};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        beats_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clk);
        end
    endtask

    // wait for every result, let trailing writes settle, then write the limit
    task automatic set_limit(logic [LIMIT_W-1:0] value);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // low-utilization entry: converges in few iterations at any limit
    task automatic write_light(logic [3:0] idx);
        logic [15:0] per;
        per = 16'($urandom_range(1024, 65535));
        send_beat(OP_WRITE, idx, 16'($urandom_range(1, per >> 6)), per);
    endtask

    initial
    begin
        bit          light;
        logic [15:0] per;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed
        set_limit(LIMIT_RESET);
        send_beat(OP_WRITE, 4'd0, 16'd0, 16'd5);        // all execution times zero
        send_beat(OP_ANALYZE, 4'd0, 16'd0, 16'd0);
        send_beat(OP_WRITE, 4'd0, 16'd1, 16'd0);        // zero period
        send_beat(OP_ANALYZE, 4'd0, 16'hFFFF, 16'hFFFF);
        send_beat(OP_WRITE, 4'd1, 16'hFFFF, 16'hFFFF);
        send_beat(OP_ANALYZE, 4'd1, 16'd0, 16'd0);      // overload, hits the limit
        send_beat(OP_WRITE, 4'd0, 16'd1, 16'hFFFF);
        send_beat(OP_ANALYZE, 4'd1, 16'd0, 16'd0);
        send_beat(OP_ANALYZE, 4'd0, 16'd0, 16'd0);
        send_beat(OP_WRITE, 4'd15, 16'hFFFF, 16'hFFFF);
        set_limit(20'd1);
        send_beat(OP_ANALYZE, 4'd0, 16'd0, 16'd0);
        send_beat(OP_ANALYZE, 4'd1, 16'd0, 16'd0);
        set_limit(20'd65536);
        send_beat(OP_ANALYZE, 4'd1, 16'd0, 16'd0);

        // random phases: light tables at large limits, arbitrary tables at small ones
        for (int ph = 0; ph < 6; ph++)
        begin
            light = (ph % 2 == 0);
            if (light)
            begin
                set_limit(ph == 0 ? LIMIT_RESET : LIMIT_W'($urandom_range(1, 1048575)));
                for (int k = 0; k < 16; k++)
                    write_light(4'(k));
            end
            else
                set_limit(LIMIT_W'($urandom_range(1, 1024)));
            for (int n = 0; n < 60; n++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    if (light)
                        write_light(4'($urandom_range(0, 15)));
                    else
                    begin
                        per = 16'($urandom);
                        send_beat(OP_WRITE, 4'($urandom_range(0, 15)), 16'($urandom), per);
                    end
                end
                else
                    send_beat(OP_ANALYZE, 4'($urandom_range(0, 15)), 16'($urandom),
                              16'($urandom));
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("busy_period_analyzer_core_tb: done, clean");
        else
            $display("busy_period_analyzer_core_tb: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_cell.sv
hw/rtl/busy_period_analyzer_core.sv
hw/rtl/bpa_checker.sv
bench/busy_period_checker.sv
bench/busy_period_analyzer_core_tb.sv
